// ----- src/ntts_pkg.sv -----
// Package for the note table tone sequencer.
// Holds sizes, register indexes, payload and command structs, and the sine table builder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ntts_pkg;

    localparam int NOTE_SLOTS      = 16;
    localparam int SLOT_BITS       = $clog2(NOTE_SLOTS);
    localparam int SINE_TABLE_BITS = 10;
    localparam int ROM_SIZE        = 1 << SINE_TABLE_BITS;
    localparam int PHASE_BITS      = 32;
    localparam int LENGTH_BITS     = 24;
    localparam int SINE_BITS       = 15;
    localparam int MAG_BITS        = 30;
    localparam int ENV_BITS        = 16;
    localparam int PROD_BITS       = MAG_BITS + ENV_BITS;
    localparam int DIV_RADIX_BITS  = 3;
    localparam int DIV_STEPS       = 16;
    localparam int DVD_BITS        = DIV_RADIX_BITS * DIV_STEPS;
    localparam int CFG_DATA_BITS   = 16;

    typedef enum logic [1:0] {
        REG_NOTE_COUNT = 2'd0,
        REG_ENVELOPE   = 2'd1,
        REG_AMPLITUDE  = 2'd2,
        REG_FORMAT     = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        FMT_FLOAT32 = 2'd0,
        FMT_PCM16   = 2'd1,
        FMT_PCM32   = 2'd2,
        FMT_SILENCE = 2'd3
    } t_format;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  slot_index;
        logic [31:0] phase_step;
        logic [23:0] note_length;
    } t_in_item;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic [3:0]  playing_slot;
        logic        note_began;
    } t_out_item;

    typedef struct packed {
        logic load_wr;
        logic fetch;
        logic start;
        logic rom_rd;
        logic scale;
        logic env_mul;
        logic div_step;
        logic norm_step;
        logic pack;
    } t_cmd;

    typedef struct packed {
        logic fade;
        logic div_last;
        logic norm_done;
        logic out_free;
    } t_status;

    typedef logic [SINE_BITS-1:0] t_rom [ROM_SIZE];

    function automatic t_rom build_sine_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        for (int i = 0; i < ROM_SIZE; i++) begin
            x  = ((64'(2 * i) + 64'd1) * 64'd1686629713) >> (SINE_TABLE_BITS + 1);
            x2 = (x * x) >> 30;
            t  = (64'd1 << 30) - x2 / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            r  = (x * t) >> 30;
            rom[i] = SINE_BITS'((r * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

// ----- src/ntts_ctrl.sv -----
// Controller state machine of the tone sequencer.
// Issues note table loads and sequences fetch, note start, sine lookup, scaling, envelope multiply,
// envelope divide (only in a fade), normalize, pack. Depends on ntts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ntts_ctrl import ntts_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  wire     i_in_func,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_START  = 8'b0000_0010,
        ST_ROM    = 8'b0000_0100,
        ST_SCALE  = 8'b0000_1000,
        ST_ENVMUL = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_NORM   = 8'b0100_0000,
        ST_PACK   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_wr = accept && (i_in_func == FUNC_LOAD);
                o_cmd.fetch   = accept && (i_in_func == FUNC_TICK);
                if (o_cmd.fetch) n_state = ST_START;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_ROM;
            end
            ST_ROM: begin
                o_cmd.rom_rd = 1'b1;
                n_state      = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_ENVMUL;
            end
            ST_ENVMUL: begin
                o_cmd.env_mul = 1'b1;
                n_state       = i_status.fade ? ST_DIV : ST_NORM;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = ST_NORM;
            end
            ST_NORM: begin
                o_cmd.norm_step = !i_status.norm_done;
                if (i_status.norm_done) n_state = ST_PACK;
            end
            ST_PACK: begin
                o_cmd.pack = i_status.out_free;
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_fetch_then_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fetch |=> o_cmd.start) else $error("start did not follow fetch");
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> o_in_stall) else $error("input open while busy");
    a_pack_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pack |=> !o_cmd.pack) else $error("double pack");

endmodule
`default_nettype wire

// ----- src/ntts_datapath.sv -----
// Datapath of the tone sequencer: note table, config registers, phase accumulator,
// sine table, scaling, serial envelope divider, float normalizer and output register.
// Depends on ntts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ntts_datapath import ntts_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_in_item                i_in_item,
    input  wire                     i_cfg_we,
    input  wire [1:0]               i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0] i_cfg_data,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  wire                     i_out_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_item
);

    localparam t_rom SINE_ROM = build_sine_rom();

    logic [PHASE_BITS+LENGTH_BITS-1:0] r_table [NOTE_SLOTS];

    logic [4:0]            r_note_count;
    logic [ENV_BITS-1:0]   r_env;
    logic [14:0]           r_amp;
    logic [1:0]            r_fmt;

    logic                  r_started;
    logic                  r_start_req;
    logic [SLOT_BITS-1:0]  r_nxt_slot;
    logic [PHASE_BITS+LENGTH_BITS-1:0] r_tbl_q;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [LENGTH_BITS-1:0] r_pos;
    logic [LENGTH_BITS-1:0] r_len;
    logic [PHASE_BITS-1:0] r_step;
    logic [PHASE_BITS-1:0] r_phase;

    logic [SINE_BITS-1:0]  r_rom_q;
    logic                  r_neg;
    logic                  r_rest;
    logic                  r_began;
    logic                  r_fade;
    logic [ENV_BITS-1:0]   r_num;
    logic [MAG_BITS-1:0]   r_mag;
    logic [4:0]            r_shift;
    logic [DVD_BITS-1:0]   r_dvd;
    logic [ENV_BITS:0]     r_rem;
    logic [3:0]            r_cnt;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [5:0]            cnt_eff;
    logic [SLOT_BITS:0]    slot_inc;
    logic [SLOT_BITS-1:0]  nxt_slot;
    logic [LENGTH_BITS-1:0] tbl_len;
    logic [LENGTH_BITS:0]  env_ext;
    logic [1:0]            quad;
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    logic [DVD_BITS-1:0]   dvd_n;
    logic [ENV_BITS:0]     rem_n;
    logic                  mag_nz;
    logic [23:0]           mant;
    logic                  rnd;
    logic [24:0]           mant_r;
    logic [7:0]            expo;
    logic [31:0]           fbits;
    logic [MAG_BITS+14:0]  v16_full;
    logic [MAG_BITS+30:0]  v32_full;
    logic [31:0]           v16;
    logic [31:0]           v32;
    logic [31:0]           bits;

    always_comb begin
        if (r_note_count == 5'd0) cnt_eff = 6'd1;
        else if (6'(r_note_count) > 6'(NOTE_SLOTS)) cnt_eff = 6'(NOTE_SLOTS);
        else cnt_eff = 6'(r_note_count);
        slot_inc = {1'b0, r_slot} + 1'b1;
        if (!r_started || 6'(slot_inc) >= cnt_eff) nxt_slot = '0;
        else nxt_slot = slot_inc[SLOT_BITS-1:0];
    end

    assign tbl_len = r_tbl_q[LENGTH_BITS-1:0];
    assign env_ext = {{(LENGTH_BITS+1-ENV_BITS){1'b0}}, r_env};
    assign quad    = r_phase[PHASE_BITS-1 -: 2];
    assign rom_idx = quad[0] ? ~r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS]
                             : r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];

    always_comb begin
        dvd_n = r_dvd;
        rem_n = r_rem;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            rem_n = {rem_n[ENV_BITS-1:0], dvd_n[DVD_BITS-1]};
            dvd_n = {dvd_n[DVD_BITS-2:0], 1'b0};
            if (rem_n >= {1'b0, r_env}) begin
                rem_n    = rem_n - {1'b0, r_env};
                dvd_n[0] = 1'b1;
            end
        end
    end

    assign mag_nz   = (r_mag != '0);
    assign mant     = r_mag[29:6];
    assign rnd      = r_mag[5] && ((r_mag[4:0] != '0) || r_mag[6]);
    assign mant_r   = {1'b0, mant} + 25'(rnd);
    assign expo     = 8'(8'd126 - {3'b0, r_shift}) + 8'(mant_r[24]);
    assign fbits    = mag_nz ? {r_neg, expo, mant_r[24] ? 23'd0 : mant_r[22:0]} : 32'd0;
    assign v16_full = {r_mag, 15'd0} - {15'd0, r_mag};
    assign v32_full = {r_mag, 31'd0} - {31'd0, r_mag};
    assign v16      = 32'(v16_full[MAG_BITS+14:30]);
    assign v32      = 32'(v32_full[MAG_BITS+30:30]);

    always_comb begin
        case (r_fmt)
            FMT_FLOAT32: bits = fbits;
            FMT_PCM16:   bits = (r_neg && mag_nz) ? 32'd0 - v16 : v16;
            FMT_PCM32:   bits = (r_neg && mag_nz) ? 32'd0 - v32 : v32;
            default:     bits = 32'd0;
        endcase
    end

    assign o_status.fade      = r_fade;
    assign o_status.div_last  = (r_cnt == 4'(DIV_STEPS - 1));
    assign o_status.norm_done = (r_fmt != FMT_FLOAT32) || !mag_nz || r_mag[MAG_BITS-1];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && ({1'b0, i_in_item.slot_index} < 5'(NOTE_SLOTS))) begin
            r_table[i_in_item.slot_index[SLOT_BITS-1:0]] <=
                {i_in_item.phase_step[PHASE_BITS-1:0], i_in_item.note_length[LENGTH_BITS-1:0]};
        end
        if (i_cmd.fetch) begin
            r_tbl_q    <= r_table[nxt_slot];
            r_nxt_slot <= nxt_slot;
        end
        if (i_cmd.rom_rd) begin
            r_rom_q <= SINE_ROM[rom_idx];
            r_neg   <= quad[1];
            r_rest  <= (r_step == '0);
            r_began <= (r_pos == '0);
            if ({1'b0, r_pos} < env_ext) begin
                r_fade <= 1'b1;
                r_num  <= r_pos[ENV_BITS-1:0];
            end else if ({1'b0, r_len} > env_ext && {1'b0, r_pos} > {1'b0, r_len} - env_ext) begin
                r_fade <= 1'b1;
                r_num  <= ENV_BITS'(r_len - r_pos);
            end else begin
                r_fade <= 1'b0;
                r_num  <= '0;
            end
        end
        if (i_cmd.scale) begin
            r_mag <= r_rest ? '0 : MAG_BITS'(r_rom_q * r_amp);
        end
        if (i_cmd.env_mul) begin
            r_dvd   <= DVD_BITS'(PROD_BITS'(r_mag * r_num));
            r_rem   <= '0;
            r_cnt   <= '0;
            r_shift <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= dvd_n;
            r_rem <= rem_n;
            r_cnt <= r_cnt + 1'b1;
            if (o_status.div_last) r_mag <= dvd_n[MAG_BITS-1:0];
        end
        if (i_cmd.norm_step) begin
            if (r_mag[29:22] == '0) begin
                r_mag   <= {r_mag[21:0], 8'd0};
                r_shift <= r_shift + 5'd8;
            end else begin
                r_mag   <= {r_mag[28:0], 1'b0};
                r_shift <= r_shift + 5'd1;
            end
        end
        if (i_cmd.pack) begin
            r_out.sample_bits  <= bits;
            r_out.playing_slot <= 4'(r_slot);
            r_out.note_began   <= r_began;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_count <= 5'd1;
            r_env        <= 16'd480;
            r_amp        <= 15'd4915;
            r_fmt        <= FMT_FLOAT32;
            r_started    <= 1'b0;
            r_start_req  <= 1'b0;
            r_slot       <= '0;
            r_pos        <= '0;
            r_len        <= '0;
            r_step       <= '0;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NOTE_COUNT: r_note_count <= i_cfg_data[4:0];
                    REG_ENVELOPE:   r_env        <= i_cfg_data[ENV_BITS-1:0];
                    REG_AMPLITUDE:  r_amp        <= i_cfg_data[14:0];
                    default:        r_fmt        <= i_cfg_data[1:0];
                endcase
            end
            if (i_cmd.fetch) begin
                r_start_req <= !r_started || (r_pos >= r_len);
                r_started   <= 1'b1;
            end
            if (i_cmd.start && r_start_req) begin
                r_slot  <= r_nxt_slot;
                r_pos   <= '0;
                r_step  <= r_tbl_q[PHASE_BITS+LENGTH_BITS-1:LENGTH_BITS];
                r_len   <= (tbl_len == '0) ? LENGTH_BITS'(1) : tbl_len;
                r_phase <= '0;
            end
            if (i_cmd.rom_rd) begin
                r_pos <= r_pos + 1'b1;
                if (r_step != '0) r_phase <= r_phase + r_step;
            end
            if (i_cmd.pack) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    a_fade_below_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.env_mul && r_fade) |-> (r_num < r_env)) else $error("fade numerator too large");
    a_norm_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pack && r_fmt == FMT_FLOAT32) |-> (!mag_nz || r_mag[MAG_BITS-1]))
        else $error("float not normalized");
    a_started_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started) else $error("started flag dropped");

endmodule
`default_nettype wire

// ----- src/note_table_tone_sequencer.sv -----
// Top level of the note table tone sequencer: controller plus datapath.
// Depends on ntts_pkg, ntts_ctrl and ntts_datapath.
//
// One item at a time. A load is written to the note table as it is accepted. A
// tick passes through start, sine lookup, scaling and envelope multiply, then the
// radix-8 envelope divider when the sample lies in a fade, then float normalize
// steps (8/1 bit shifts) when the format is float32, then pack. The result sits
// in an output register, so the next item can be taken while it waits; a tick that
// finishes while a held result is stalled waits in pack. Config writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module note_table_tone_sequencer import ntts_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output t_out_item               o_out_item,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [1:0]               i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ntts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_item.func),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ntts_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ----- tb/ntts_checker.sv -----
// Checker for the note table tone sequencer: watches the item, result and register channels,
// predicts each frame sample and compares it field by field.
// Depends on ntts_pkg.
`timescale 1ns / 1ps
module ntts_checker import ntts_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     i_in_stall,
    input  t_in_item                i_in_item,
    input  wire                     i_out_valid,
    input  wire                     i_out_stall,
    input  t_out_item               i_out_item,
    input  wire                     i_cfg_valid,
    input  wire                     i_cfg_ready,
    input  wire [1:0]               i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);

    logic [31:0] step_tbl [NOTE_SLOTS];
    logic [23:0] len_tbl  [NOTE_SLOTS];
    logic [14:0] sine_rom [ROM_SIZE];
    logic [3:0]  cur_slot;
    logic [23:0] pos;
    logic [23:0] cur_len;
    logic [31:0] cur_step;
    logic [31:0] phase;
    logic        started;
    logic [4:0]  note_cnt;
    logic [15:0] env_len;
    logic [14:0] amp;
    t_format     fmt;
    t_out_item   sample_q [$];

    function automatic logic [14:0] quarter_wave(int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] denom [5];
        denom = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        x  = ((64'd2 * i + 64'd1) * 64'd1686629713) >> 11;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        foreach (denom[k])
            t = (64'd1 << 30) - ((x2 * t) >> 30) / denom[k];
        t = (x * t) >> 30;
        return 15'((t * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic logic [31:0] to_single(bit neg, logic [63:0] mag);
        int          b;
        int          sh;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        if (mag == 0)
            return 32'd0;
        b = 29;
        while (b > 0 && !mag[b])
            b--;
        if (b <= 23) begin
            mant = mag << (23 - b);
        end else begin
            sh   = b - 23;
            rem  = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            mant = mag >> sh;
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant[24]) begin
                mant = mant >> 1;
                b++;
            end
        end
        return {neg, 8'(b - 30 + 127), mant[22:0]};
    endfunction

    task automatic begin_note(int unsigned s);
        cur_slot = 4'(s);
        pos      = '0;
        cur_step = step_tbl[s];
        cur_len  = (len_tbl[s] != 0) ? len_tbl[s] : 24'd1;
        phase    = '0;
    endtask

    task automatic predict_sample();
        int unsigned cnt;
        int unsigned nxt;
        logic [1:0]  quad;
        logic [9:0]  idx;
        logic [63:0] mag;
        logic [63:0] v;
        bit          neg;
        t_out_item   want;
        if (!started) begin
            started = 1'b1;
            begin_note(0);
        end else if (pos >= cur_len) begin
            cnt = (note_cnt == 0) ? 1 : note_cnt;
            if (cnt > NOTE_SLOTS)
                cnt = NOTE_SLOTS;
            nxt = cur_slot + 1;
            if (nxt >= cnt)
                nxt = 0;
            begin_note(nxt);
        end
        want.note_began   = (pos == 0);
        want.playing_slot = cur_slot;
        mag = '0;
        neg = 1'b0;
        if (cur_step != 0) begin
            quad = phase[31:30];
            idx  = phase[29:20];
            if (quad[0])
                idx = ~idx;
            neg = quad[1];
            mag = 64'(sine_rom[idx]) * 64'(amp);
            if (pos < env_len)
                mag = mag * 64'(pos) / 64'(env_len);
            else if (cur_len > env_len && pos > cur_len - env_len)
                mag = mag * 64'(cur_len - pos) / 64'(env_len);
            phase = phase + cur_step;
        end
        if (mag == 0)
            neg = 1'b0;
        case (fmt)
            FMT_FLOAT32: want.sample_bits = to_single(neg, mag);
            FMT_PCM16: begin
                v = (mag * 64'd32767) >> 30;
                if (neg) begin
                    if (v > 64'd32768) v = 64'd32768;
                    want.sample_bits = 32'd0 - v[31:0];
                end else begin
                    if (v > 64'd32767) v = 64'd32767;
                    want.sample_bits = v[31:0];
                end
            end
            FMT_PCM32: begin
                v = (mag * 64'd2147483647) >> 30;
                if (neg) begin
                    if (v > 64'd2147483648) v = 64'd2147483648;
                    want.sample_bits = 32'd0 - v[31:0];
                end else begin
                    if (v > 64'd2147483647) v = 64'd2147483647;
                    want.sample_bits = v[31:0];
                end
            end
            default: want.sample_bits = '0;
        endcase
        pos = pos + 24'd1;
        sample_q.push_back(want);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        for (int i = 0; i < ROM_SIZE; i++)
            sine_rom[i] = quarter_wave(i);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (step_tbl[i]) begin
                step_tbl[i] = '0;
                len_tbl[i]  = '0;
            end
            cur_slot = '0;
            pos      = '0;
            cur_len  = '0;
            cur_step = '0;
            phase    = '0;
            started  = 1'b0;
            note_cnt = 5'd1;
            env_len  = 16'd480;
            amp      = 15'd4915;
            fmt      = FMT_FLOAT32;
            sample_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_index'(i_cfg_index))
                    REG_NOTE_COUNT: note_cnt = i_cfg_data[4:0];
                    REG_ENVELOPE:   env_len  = i_cfg_data[15:0];
                    REG_AMPLITUDE:  amp      = i_cfg_data[14:0];
                    default:        fmt      = t_format'(i_cfg_data[1:0]);
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    report_mismatch("unexpected sample", i_out_item.sample_bits, '0);
                end else begin
                    want = sample_q.pop_front();
                    if (i_out_item.sample_bits !== want.sample_bits)
                        report_mismatch("sample_bits", i_out_item.sample_bits,
                                        want.sample_bits);
                    if (i_out_item.playing_slot !== want.playing_slot)
                        report_mismatch("playing_slot", 32'(i_out_item.playing_slot),
                                        32'(want.playing_slot));
                    if (i_out_item.note_began !== want.note_began)
                        report_mismatch("note_began", 32'(i_out_item.note_began),
                                        32'(want.note_began));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.func == FUNC_TICK) begin
                    predict_sample();
                end else begin
                    step_tbl[i_in_item.slot_index] = i_in_item.phase_step;
                    len_tbl[i_in_item.slot_index]  = i_in_item.note_length;
                end
            end
        end
        o_pending = sample_q.size();
    end

endmodule

// ----- tb/note_table_tone_sequencer_test.sv -----
// Testbench top for the note table tone sequencer: drives note loads, ticks and
// register writes with random idling, and gives the verdict from ntts_checker's count
// or a watchdog timeout. Depends on ntts_pkg, ntts_checker and note_table_tone_sequencer.
`timescale 1ns / 1ps
module note_table_tone_sequencer_test;
    import ntts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 48;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     in_stall;
    t_in_item                 in_item;
    logic                     out_valid;
    logic                     out_stall;
    t_out_item                out_item;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       errors;
    int                       pending;
    int                       quiet_cycles;
    bit                       quiet;

    note_table_tone_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ntts_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            int unsigned n;
            n = $urandom_range(1, 18);
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** note_table_tone_sequencer: FAILED **");
        $finish;
    end

    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
    endtask

    task automatic load_slot(logic [3:0] s, logic [31:0] step, logic [23:0] len);
        t_in_item it;
        it.func        = FUNC_LOAD;
        it.slot_index  = s;
        it.phase_step  = step;
        it.note_length = len;
        send_item(it);
    endtask

    task automatic tick();
        t_in_item it;
        it             = t_in_item'({$urandom, $urandom});
        it.func        = FUNC_TICK;
        send_item(it);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'($urandom_range(1, 65535)) << 12;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned nc;
        int unsigned eff;
        int unsigned s;
        logic [23:0] len;
        quiet     = 1'b0;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rest with zero length, full-scale and quadrant steps
        load_slot(4'd0, 32'd0, 24'd0);
        load_slot(4'd1, 32'hFFFF_FFFF, 24'd2);
        load_slot(4'd2, 32'h4000_0000, 24'd4);
        load_slot(4'd3, 32'h8000_0000, 24'd1);
        for (int i = 4; i < NOTE_SLOTS; i++)
            load_slot(4'(i), rand_step(), 24'($urandom_range(0, 6)));
        repeat (2) tick();
        settle();
        write_reg(REG_NOTE_COUNT, 16'd31);
        write_reg(REG_ENVELOPE, 16'd0);
        write_reg(REG_AMPLITUDE, 16'hFFFF);
        write_reg(REG_FORMAT, 16'(FMT_PCM16));
        repeat (8) tick();

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: nc = 0;
                1: nc = 16;
                2: nc = 17;
                default: nc = $urandom_range(1, 31);
            endcase
            write_reg(REG_NOTE_COUNT, {11'($urandom), 5'(nc)});
            case (ph % 3)
                0: write_reg(REG_ENVELOPE, 16'($urandom_range(0, 12)));
                1: write_reg(REG_ENVELOPE, (ph == 1) ? 16'hFFFF : 16'd0);
                default: write_reg(REG_ENVELOPE, 16'($urandom));
            endcase
            case (ph)
                2: write_reg(REG_AMPLITUDE, 16'd0);
                3: write_reg(REG_AMPLITUDE, 16'h7FFF);
                default: write_reg(REG_AMPLITUDE, 16'($urandom));
            endcase
            write_reg(REG_FORMAT, {14'($urandom), 2'(ph)});
            eff = (nc == 0) ? 1 : ((nc > NOTE_SLOTS) ? NOTE_SLOTS : nc);
            for (int i = 0; i < NOTE_SLOTS; i++)
                load_slot(4'(i), rand_step(), 24'($urandom_range(0, 30)));
            if (ph == 7)
                quiet = 1'b1;
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 6) != 0) begin
                    tick();
                end else begin
                    s   = $urandom_range(0, NOTE_SLOTS - 1);
                    len = 24'($urandom_range(0, 30));
                    // long notes only in slots that never play
                    if (s >= eff && $urandom_range(0, 1) == 0)
                        len = 24'($urandom);
                    load_slot(4'(s), rand_step(), len);
                end
            end
        end

        settle();
        if (errors == 0)
            $display("** note_table_tone_sequencer: PASSED **");
        else
            $display("** note_table_tone_sequencer: FAILED **");
        $finish;
    end

endmodule
